### rtl/text_terminal_writer_macros.svh
// Assertion macros shared by the text terminal writer modules.
`ifndef TEXT_TERMINAL_WRITER_MACROS_SVH
`define TEXT_TERMINAL_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ttw_pkg.sv
// Types, constants and codes shared by the text terminal writer.
package ttw_pkg;

  localparam int TTW_COLUMNS = 80;
  localparam int TTW_ROWS    = 25;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int X_W    = 7;
  localparam int Y_W    = 5;
  localparam int CELL_W = 16;
  localparam int HW_W   = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CHAR_W:0]   TAB_STEP     = 9'd8;
  localparam logic [CHAR_W:0]   TAB_MASK     = 9'h1F8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } ttw_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } ttw_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_run;
    logic init;
    logic load_out;
  } ttw_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic is_read;
    logic sweep_last;
    logic out_free;
  } ttw_status_t;

endpackage

### rtl/ttw_in_if.sv
// Request channel of the text terminal writer.
interface ttw_in_if;
  logic                       valid;
  logic                       ready;
  logic [ttw_pkg::MODE_W-1:0] mode;
  logic [ttw_pkg::CHAR_W-1:0] char_code;
  logic [ttw_pkg::X_W-1:0]    cursor_x;
  logic [ttw_pkg::Y_W-1:0]    cursor_y;

  modport source (output valid, output mode, output char_code, output cursor_x,
                  output cursor_y, input ready);
  modport sink (input valid, input mode, input char_code, input cursor_x,
                input cursor_y, output ready);
endinterface

### rtl/ttw_out_if.sv
// Result channel of the text terminal writer.
interface ttw_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttw_pkg::CELL_W-1:0] cell_value;
  logic [ttw_pkg::X_W-1:0]    column_now;
  logic [ttw_pkg::Y_W-1:0]    row_now;
  logic [ttw_pkg::HW_W-1:0]   hw_cursor_position;

  modport source (output valid, output cell_value, output column_now, output row_now,
                  output hw_cursor_position, input ready);
  modport sink (input valid, input cell_value, input column_now, input row_now,
                input hw_cursor_position, output ready);
endinterface

### rtl/ttw_ctrl.sv
// Sequencing state machine of the text terminal writer.
module ttw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttw_pkg::ttw_status_t status,
  output ttw_pkg::ttw_cmd_t    cmd
);
  import ttw_pkg::*;

  `include "text_terminal_writer_macros.svh"

  ttw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_run = 1'b1;
        cmd.init      = 1'b1;
        if (status.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (status.need_sweep) begin
          state_nxt = ST_SWEEP;
        end else if (status.is_read) begin
          state_nxt = ST_FINISH;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (status.sweep_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A request is applied exactly once.
  `TTW_ASSERT_NEXT(a_exec_single, state_r == ST_EXEC, state_r != ST_EXEC, "exec repeated")
  // The clearing pass after reset runs only once.
  `TTW_ASSERT_NEXT(a_init_once, state_r != ST_INIT, state_r != ST_INIT, "init re-entered")

endmodule

### rtl/ttw_datapath.sv
// Cursor registers, screen memory and sweep engine of the text terminal writer.
module ttw_datapath #(
  parameter int COLUMNS = ttw_pkg::TTW_COLUMNS,
  parameter int ROWS    = ttw_pkg::TTW_ROWS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttw_pkg::ttw_cmd_t          cmd,
  output ttw_pkg::ttw_status_t       status,
  input  logic                       cfg_write_en,
  input  logic [ttw_pkg::CHAR_W-1:0] cfg_write_data,
  input  logic [ttw_pkg::MODE_W-1:0] in_mode,
  input  logic [ttw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [ttw_pkg::X_W-1:0]    in_cursor_x,
  input  logic [ttw_pkg::Y_W-1:0]    in_cursor_y,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [ttw_pkg::CELL_W-1:0] out_cell_value,
  output logic [ttw_pkg::X_W-1:0]    out_column_now,
  output logic [ttw_pkg::Y_W-1:0]    out_row_now,
  output logic [ttw_pkg::HW_W-1:0]   out_hw_cursor_position
);
  import ttw_pkg::*;

  `include "text_terminal_writer_macros.svh"

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COPY_END = CELLS - COLUMNS;
  localparam logic [HW_W-1:0] HW_LAST = HW_W'(((ROWS - 1) * COLUMNS) % (1 << HW_W));
  localparam logic [X_W:0]    COL_LIM = (X_W + 1)'(COLUMNS);
  localparam logic [Y_W:0]    ROW_LIM = (Y_W + 1)'(ROWS);
  localparam logic [Y_W:0]    ROW_TOP = (Y_W + 1)'(ROWS - 1);

  // Latched request.
  ttw_mode_t         mode_r;
  logic [CHAR_W-1:0] ch_r;
  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;

  logic [CHAR_W-1:0] attr_r;
  logic [X_W-1:0]    col_r, col_nxt;
  logic [Y_W-1:0]    row_r, row_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;

  logic [CELL_W-1:0] screen_mem_r [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  logic [ADDR_W-1:0] ptr_r;
  logic              sweep_copy_r;
  logic              wp_r;
  logic [ADDR_W-1:0] wa_r;
  logic              wcopy_r;
  logic [CELL_W-1:0] wblank_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [X_W-1:0]    out_col_r;
  logic [Y_W-1:0]    out_row_r;
  logic [HW_W-1:0]   out_hw_r;

  logic              use_req_xy;
  logic [Y_W-1:0]    mul_row;
  logic [X_W-1:0]    mul_col;
  logic [ADDR_W-1:0] lin;
  logic              xy_ok;
  logic [X_W:0]      tab_pos;
  logic [X_W:0]      col_inc;
  logic              next_row_req;
  logic              scroll;
  logic              char_we;
  logic              rd_cell_en;

  logic              sweep_copy;
  logic              sweep_last;
  logic [ADDR_W-1:0] ptr_src;
  logic [CELL_W-1:0] blank_word;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;

  // One shared multiplier forms the linear cell position for character writes, cursor sets and reads.
  assign use_req_xy = (mode_r == MODE_SET) || (mode_r == MODE_READ);
  assign mul_row    = use_req_xy ? y_r : row_r;
  assign mul_col    = use_req_xy ? x_r : col_r;
  assign lin        = ADDR_W'(int'(mul_row) * COLUMNS + int'(mul_col));
  assign xy_ok      = ({1'b0, x_r} < COL_LIM) && ({1'b0, y_r} < ROW_LIM);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    hw_nxt       = hw_r;
    next_row_req = 1'b0;
    scroll       = 1'b0;
    char_we      = 1'b0;
    rd_cell_en   = 1'b0;
    tab_pos      = ({1'b0, col_r} + TAB_STEP[X_W:0]) & TAB_MASK[X_W:0];
    col_inc      = {1'b0, col_r} + (X_W + 1)'(1);
    if (cmd.exec) begin
      unique case (mode_r)
        MODE_PUT: begin
          unique case (ch_r)
            CH_NEWLINE: next_row_req = 1'b1;
            CH_RETURN:  col_nxt = '0;
            CH_TAB: begin
              if (tab_pos >= COL_LIM) next_row_req = 1'b1;
              else col_nxt = tab_pos[X_W-1:0];
            end
            CH_BACKSPACE: begin
              if (col_r != '0) col_nxt = col_r - X_W'(1);
            end
            default: begin
              char_we = 1'b1;
              // The cursor is the written cell plus one, also across a row end, except on a scroll.
              hw_nxt  = HW_W'(lin) + HW_W'(1);
              if (col_inc == COL_LIM) next_row_req = 1'b1;
              else col_nxt = col_inc[X_W-1:0];
            end
          endcase
          if (next_row_req) begin
            col_nxt = '0;
            if ({1'b0, row_r} == ROW_TOP) begin
              scroll = 1'b1;
              hw_nxt = HW_LAST;
            end else begin
              row_nxt = row_r + Y_W'(1);
            end
          end
        end
        MODE_SET: begin
          if (xy_ok) begin
            col_nxt = x_r;
            row_nxt = y_r;
            hw_nxt  = HW_W'(lin);
          end
        end
        MODE_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        MODE_READ: rd_cell_en = xy_ok;
        default: rd_cell_en = 1'b0;
      endcase
    end
  end

  // Sweep engine: one cell a cycle; a copied cell is written in the cycle after its read.
  assign sweep_copy = sweep_copy_r && (ptr_r < ADDR_W'(COPY_END));
  assign sweep_last = (ptr_r == ADDR_W'(CELLS - 1));
  assign ptr_src    = ADDR_W'(int'(ptr_r) + COLUMNS);
  assign blank_word = cmd.init ? {RESET_ATTR, BLANK_CHAR} : {attr_r, BLANK_CHAR};

  assign rd_en   = (cmd.sweep_run && sweep_copy) || rd_cell_en;
  assign rd_addr = cmd.sweep_run ? ptr_src : lin;
  assign mem_we  = wp_r || char_we;
  assign mem_wa  = wp_r ? wa_r : lin;
  assign mem_wd  = wp_r ? (wcopy_r ? rd_data_r : wblank_r) : {attr_r, ch_r};

  always_ff @(posedge clk) begin
    if (mem_we) screen_mem_r[mem_wa] <= mem_wd;
    if (rd_en)  rd_data_r <= screen_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= ttw_mode_t'(in_mode);
      ch_r   <= in_char_code;
      x_r    <= in_cursor_x;
      y_r    <= in_cursor_y;
    end
    if (cmd.sweep_run) begin
      wa_r     <= ptr_r;
      wcopy_r  <= sweep_copy;
      wblank_r <= blank_word;
    end
    if (cmd.load_out) begin
      out_cell_r <= ((mode_r == MODE_READ) && xy_ok) ? rd_data_r : '0;
      out_col_r  <= col_nxt;
      out_row_r  <= row_nxt;
      out_hw_r   <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r       <= RESET_ATTR;
      col_r        <= '0;
      row_r        <= '0;
      hw_r         <= '0;
      ptr_r        <= '0;
      sweep_copy_r <= 1'b0;
      wp_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_en) attr_r <= cfg_write_data;
      col_r <= col_nxt;
      row_r <= row_nxt;
      hw_r  <= hw_nxt;
      if (cmd.exec) sweep_copy_r <= (mode_r == MODE_PUT);
      if (cmd.sweep_run) ptr_r <= sweep_last ? '0 : ptr_r + ADDR_W'(1);
      wp_r <= cmd.sweep_run;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign status.need_sweep = scroll || (mode_r == MODE_CLEAR);
  assign status.is_read    = (mode_r == MODE_READ);
  assign status.sweep_last = sweep_last;
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid              = out_valid_r;
  assign out_cell_value         = out_cell_r;
  assign out_column_now         = out_col_r;
  assign out_row_now            = out_row_r;
  assign out_hw_cursor_position = out_hw_r;

  `TTW_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_r || out_ready,
                   "result overwritten before transfer")
  `TTW_ASSERT_SAME(a_exec_no_pending, cmd.exec, !wp_r, "sweep write pending during exec")
  `TTW_ASSERT_SAME(a_ptr_home, ptr_r != '0, $past(cmd.sweep_run), "sweep pointer left mid-screen")
  `TTW_ASSERT_SAME(a_cursor_range, 1'b1, ({1'b0, col_r} < COL_LIM) && ({1'b0, row_r} < ROW_LIM),
                   "cursor outside the screen")

endmodule

### rtl/text_terminal_writer.sv
// Top level of the text terminal writer: controller, datapath and channel hookup.
//
// Put (unless it scrolls), set-cursor and cursor-only control codes load their
// result in the EXEC state if the output is free; a cell read also passes through
// the FINISH state because the screen memory read is registered. Clear and any put
// that scrolls walk the whole screen memory one cell per cycle through its single
// write port. After reset a clearing pass fills the screen with spaces in
// attribute 0x07, during which no request is taken; the attribute register can be
// written at any time the block is idle, including during that pass.
module text_terminal_writer #(
  parameter int COLUMNS = ttw_pkg::TTW_COLUMNS,
  parameter int ROWS    = ttw_pkg::TTW_ROWS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_write_en,
  input  logic [ttw_pkg::CHAR_W-1:0] cfg_write_data,
  ttw_in_if.sink                     in_ch,
  ttw_out_if.source                  out_ch
);
  import ttw_pkg::*;

  ttw_cmd_t    cmd;
  ttw_status_t status;

  ttw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .cfg_write_en           (cfg_write_en),
    .cfg_write_data         (cfg_write_data),
    .in_mode                (in_ch.mode),
    .in_char_code           (in_ch.char_code),
    .in_cursor_x            (in_ch.cursor_x),
    .in_cursor_y            (in_ch.cursor_y),
    .out_ready              (out_ch.ready),
    .out_valid              (out_ch.valid),
    .out_cell_value         (out_ch.cell_value),
    .out_column_now         (out_ch.column_now),
    .out_row_now            (out_ch.row_now),
    .out_hw_cursor_position (out_ch.hw_cursor_position)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the text terminal writer: random and directed requests, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import ttw_pkg::*;

  localparam int COLS           = TTW_COLUMNS;
  localparam int LINES          = TTW_ROWS;
  localparam int CELLS          = COLS * LINES;
  localparam int TAB_STOP       = 8;
  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 100;
  localparam int PHASES         = 5;

  typedef struct {
    ttw_mode_t         mode;
    logic [CHAR_W-1:0] char_code;
    logic [X_W-1:0]    cursor_x;
    logic [Y_W-1:0]    cursor_y;
  } request_t;

  typedef struct {
    logic [CELL_W-1:0] cell_value;
    logic [X_W-1:0]    column_now;
    logic [Y_W-1:0]    row_now;
    logic [HW_W-1:0]   hw_cursor_position;
  } status_t;

  // Tracks the screen, cursor and attribute, and holds the status words still to come.
  class screen_tracker;
    logic [CELL_W-1:0] cells [0:CELLS-1];
    int unsigned       col;
    int unsigned       row;
    logic [HW_W-1:0]   hw_cursor;
    logic [CHAR_W-1:0] attr;
    status_t           pending_status [$];
    int                errors;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = {RESET_ATTR, BLANK_CHAR};
      col = 0;
      row = 0;
      hw_cursor = '0;
      attr = RESET_ATTR;
      errors = 0;
    endfunction

    function void set_attr(logic [CHAR_W-1:0] a);
      attr = a;
    endfunction

    function void load_hw_cursor();
      hw_cursor = HW_W'(row * COLS + col);
    endfunction

    function void scroll_up();
      for (int i = 0; i + COLS < CELLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {attr, BLANK_CHAR};
      row = LINES - 1;
      load_hw_cursor();
    endfunction

    function void next_row();
      col = 0;
      row++;
      if (row >= LINES) scroll_up();
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch);
      if (ch == CH_NEWLINE) begin
        next_row();
      end else if (ch == CH_RETURN) begin
        col = 0;
      end else if (ch == CH_TAB) begin
        col = (col / TAB_STOP + 1) * TAB_STOP;
        if (col >= COLS) next_row();
      end else if (ch == CH_BACKSPACE) begin
        if (col > 0) col--;
      end else begin
        cells[row * COLS + col] = {attr, ch};
        col++;
        if (col >= COLS) next_row();
        load_hw_cursor();
      end
    endfunction

    function void note_request(request_t r);
      status_t s;
      s.cell_value = '0;
      case (r.mode)
        MODE_PUT: begin
          put_char(r.char_code);
        end
        MODE_SET: begin
          if (r.cursor_x < COLS && r.cursor_y < LINES) begin
            col = 32'(r.cursor_x);
            row = 32'(r.cursor_y);
            load_hw_cursor();
          end
        end
        MODE_CLEAR: begin
          for (int i = 0; i < CELLS; i++) cells[i] = {attr, BLANK_CHAR};
          col = 0;
          row = 0;
        end
        default: begin
          if (r.cursor_x < COLS && r.cursor_y < LINES)
            s.cell_value = cells[r.cursor_y * COLS + r.cursor_x];
        end
      endcase
      s.column_now = X_W'(col);
      s.row_now = Y_W'(row);
      s.hw_cursor_position = hw_cursor;
      pending_status.push_back(s);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (pending_status.size() == 0) begin
        flag_error($sformatf("result with nothing outstanding: cell=%h col=%0d row=%0d hw=%0d",
                             got.cell_value, got.column_now, got.row_now,
                             got.hw_cursor_position));
        return;
      end
      want = pending_status.pop_front();
      if (got.cell_value !== want.cell_value || got.column_now !== want.column_now ||
          got.row_now !== want.row_now ||
          got.hw_cursor_position !== want.hw_cursor_position) begin
        flag_error($sformatf({"mismatch: expected cell=%h col=%0d row=%0d hw=%0d, ",
                              "got cell=%h col=%0d row=%0d hw=%0d"},
                             want.cell_value, want.column_now, want.row_now,
                             want.hw_cursor_position, got.cell_value, got.column_now,
                             got.row_now, got.hw_cursor_position));
      end
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_write_en;
  logic [CHAR_W-1:0] cfg_write_data;

  ttw_in_if  in_ch ();
  ttw_out_if out_ch ();

  screen_tracker sb;
  bit            send_quiet;
  bit            recv_quiet;
  bit            hold_request;

  text_terminal_writer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly no gap, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic request_t make_request(ttw_mode_t m, logic [CHAR_W-1:0] ch,
                                            logic [X_W-1:0] x, logic [Y_W-1:0] y);
    request_t r;
    r.mode = m;
    r.char_code = ch;
    r.cursor_x = x;
    r.cursor_y = y;
    return r;
  endfunction

  // Mostly running text with some control codes; reads favor cells just written.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       sub;
    r.char_code = CHAR_W'($urandom_range(0, 255));
    r.cursor_x = X_W'($urandom_range(0, 127));
    r.cursor_y = Y_W'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    if (pick < 66) begin
      r.mode = MODE_PUT;
      if (sub < 6) r.char_code = CH_NEWLINE;
      else if (sub < 10) r.char_code = CH_TAB;
      else if (sub < 13) r.char_code = CH_RETURN;
      else if (sub < 17) r.char_code = CH_BACKSPACE;
      else if (sub >= 22) r.char_code = CHAR_W'($urandom_range(8'h21, 8'h7E));
    end else if (pick < 76) begin
      r.mode = MODE_SET;
      if (sub < 80) begin
        r.cursor_x = X_W'($urandom_range(0, COLS - 1));
        r.cursor_y = Y_W'($urandom_range(0, LINES - 1));
      end
    end else if (pick < 78) begin
      r.mode = MODE_CLEAR;
    end else begin
      r.mode = MODE_READ;
      if (sub < 70) begin
        r.cursor_y = Y_W'(sb.row);
        r.cursor_x = (sb.col > 0) ? X_W'($urandom_range(0, sb.col - 1)) : '0;
      end else if (sub < 85) begin
        r.cursor_x = X_W'($urandom_range(0, COLS - 1));
        r.cursor_y = Y_W'($urandom_range(0, LINES - 1));
      end
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= r.mode;
    in_ch.char_code <= r.char_code;
    in_ch.cursor_x <= r.cursor_x;
    in_ch.cursor_y <= r.cursor_y;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [CHAR_W-1:0] a);
    cfg_write_en <= 1'b1;
    cfg_write_data <= a;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_attr(a);
  endtask

  // Result side: checks each transfer and drives ready with random stalls.
  initial begin
    int      stall_left;
    status_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.cell_value = out_ch.cell_value;
        got.column_now = out_ch.column_now;
        got.row_now = out_ch.row_now;
        got.hw_cursor_position = out_ch.hw_cursor_position;
        sb.check_status(got);
      end
      if (hold_request) begin
        // Long hold-off so the block fills up and stalls its input.
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_left = 0;
      end
      if (stall_left == 0 && !recv_quiet && $urandom_range(0, 2) == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    request_t          plan [$];
    logic [CHAR_W-1:0] attrs [PHASES];
    sb = new();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_PUT;
    in_ch.char_code <= '0;
    in_ch.cursor_x <= '0;
    in_ch.cursor_y <= '0;
    out_ch.ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(make_request(MODE_PUT, 8'h48, 0, 0));
    plan.push_back(make_request(MODE_PUT, 8'h00, 0, 0));
    plan.push_back(make_request(MODE_PUT, 8'hFF, 0, 0));
    plan.push_back(make_request(MODE_READ, 8'h00, 0, 0));
    plan.push_back(make_request(MODE_READ, 8'h00, 2, 0));
    plan.push_back(make_request(MODE_PUT, CH_BACKSPACE, 0, 0));
    plan.push_back(make_request(MODE_PUT, CH_TAB, 0, 0));
    plan.push_back(make_request(MODE_PUT, CH_RETURN, 0, 0));
    plan.push_back(make_request(MODE_PUT, CH_BACKSPACE, 0, 0));
    plan.push_back(make_request(MODE_PUT, CH_NEWLINE, 0, 0));
    plan.push_back(make_request(MODE_SET, 8'h00, 7'd127, 5'd31));
    plan.push_back(make_request(MODE_SET, 8'h00, X_W'(COLS), 0));
    plan.push_back(make_request(MODE_SET, 8'h00, 0, Y_W'(LINES)));
    plan.push_back(make_request(MODE_SET, 8'h00, 75, 10));
    // Tab past the right edge wraps to the next row without moving the hardware cursor.
    plan.push_back(make_request(MODE_PUT, CH_TAB, 0, 0));
    plan.push_back(make_request(MODE_SET, 8'h00, X_W'(COLS - 1), Y_W'(LINES - 1)));
    // A character in the last cell wraps and scrolls the screen.
    plan.push_back(make_request(MODE_PUT, 8'h5A, 0, 0));
    plan.push_back(make_request(MODE_READ, 8'h00, X_W'(COLS - 1), Y_W'(LINES - 2)));
    plan.push_back(make_request(MODE_READ, 8'h00, 7'd127, 5'd31));
    plan.push_back(make_request(MODE_READ, 8'h00, 0, Y_W'(LINES)));
    plan.push_back(make_request(MODE_PUT, CH_NEWLINE, 0, 0));
    plan.push_back(make_request(MODE_CLEAR, 8'h00, 0, 0));
    plan.push_back(make_request(MODE_READ, 8'h00, X_W'(COLS - 1), Y_W'(LINES - 2)));
    plan.push_back(make_request(MODE_PUT, 8'h7E, 0, 0));
    foreach (plan[i]) send_request(plan[i]);
    drain();

    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    attrs[2] = CHAR_W'($urandom_range(0, 255));
    attrs[3] = 8'h1E;
    attrs[4] = CHAR_W'($urandom_range(0, 255));
    for (int p = 0; p < PHASES; p++) begin
      write_attribute(attrs[p]);
      send_quiet = (p == 1 || p == 2);
      recv_quiet = (p == 2 || p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) hold_request = 1'b1;
        send_request(random_request());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ttw_pkg.sv
rtl/ttw_in_if.sv
rtl/ttw_out_if.sv
rtl/ttw_ctrl.sv
rtl/ttw_datapath.sv
rtl/text_terminal_writer.sv
sim/tb_top.sv
